@@ sv/texture_wrap_address_unit_assert.svh @@
// Assertion helpers shared by the address unit modules.
// Both sample on clk and are quiet while rst_n is low.
`ifndef TEXTURE_WRAP_ADDRESS_UNIT_ASSERT_SVH
`define TEXTURE_WRAP_ADDRESS_UNIT_ASSERT_SVH

// Same-cycle implication.
`define TWA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TWA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/twa_pkg.sv @@
`timescale 1ns / 1ps

package twa_pkg;

  localparam int AXES       = 2;
  localparam int COORD_W    = 24;
  localparam int SIZE_REG_W = 13;
  localparam int STRIDE_W   = 16;
  localparam int BPT_W      = 4;
  localparam int TEXEL_W    = 12;
  localparam int OFFSET_W   = 27;
  localparam int WORD_W     = 25;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEX_WIDTH       = 2'd0,
    REG_TEX_HEIGHT      = 2'd1,
    REG_ROW_STRIDE      = 2'd2,
    REG_BYTES_PER_TEXEL = 2'd3
  } cfg_reg_t;

  // Per-word control handed along the pipeline: valid plus sign of each axis.
  typedef struct packed {
    logic            valid;
    logic [AXES-1:0] neg;
  } twa_ctl_t;

endpackage

@@ sv/texture_wrap_address_unit.sv @@
`timescale 1ns / 1ps
// Texture wrap address unit, repeat wrap, nearest texel.
// Input: pulse start with in_coord_u / in_coord_v (signed, COORD_FRAC_BITS
// fraction bits). busy is held low, so a word is taken on every cycle start
// is high, back to back.
// Output: out_valid is high for one cycle with out_texel_col, out_texel_row,
// out_byte_offset and out_word_index; the receiver must take it then.
// Pipeline: scaling (product register, then sign and magnitude registers),
// one cell per dividend bit in the cell chain (one restoring-division step
// per cell), then wrap fix and offset multiply-add (index, product and
// output registers). Throughput is one word per cycle.
// Config: cfg_we, cfg_index, cfg_wdata write one register per cycle:
// 0 texture width, 1 texture height, 2 row stride bytes, 3 bytes per texel.
// Write only while no word is in flight. Sizes of 0 act as 1 and sizes
// above MAX_DIM act as MAX_DIM.
// Reset (rst_n low, synchronous) empties the pipeline and loads width 1,
// height 1, stride 4, bytes per texel 4.
module texture_wrap_address_unit
  import twa_pkg::*;
#(
  parameter int MAX_DIM         = 4096,
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [COORD_W-1:0]    in_coord_u,
  input  logic [COORD_W-1:0]    in_coord_v,
  output logic                  out_valid,
  output logic [TEXEL_W-1:0]    out_texel_col,
  output logic [TEXEL_W-1:0]    out_texel_row,
  output logic [OFFSET_W-1:0]   out_byte_offset,
  output logic [WORD_W-1:0]     out_word_index,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int R_W = $clog2(MAX_DIM);
  localparam int T_W = R_W + 1;
  localparam int D_W = COORD_W + T_W + 1 - COORD_FRAC_BITS;

  logic [SIZE_REG_W-1:0] width_r;
  logic [SIZE_REG_W-1:0] height_r;
  logic [STRIDE_W-1:0]   stride_r;
  logic [BPT_W-1:0]      bpt_r;

  logic [T_W-1:0]              eff_w;
  logic [T_W-1:0]              eff_h;
  logic [AXES-1:0][T_W-1:0]    size_eff;

  twa_ctl_t                    ctl_w [D_W+1];
  logic [AXES-1:0][R_W-1:0]    rem_w [D_W+1];
  logic [AXES-1:0][D_W-1:0]    dvd_w [D_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= SIZE_REG_W'(1);
      height_r <= SIZE_REG_W'(1);
      stride_r <= STRIDE_W'(4);
      bpt_r    <= BPT_W'(4);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TEX_WIDTH:       width_r  <= cfg_wdata[SIZE_REG_W-1:0];
        REG_TEX_HEIGHT:      height_r <= cfg_wdata[SIZE_REG_W-1:0];
        REG_ROW_STRIDE:      stride_r <= cfg_wdata[STRIDE_W-1:0];
        REG_BYTES_PER_TEXEL: bpt_r    <= cfg_wdata[BPT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (width_r == '0) begin
      eff_w = T_W'(1);
    end else if (32'(width_r) > MAX_DIM) begin
      eff_w = T_W'(MAX_DIM);
    end else begin
      eff_w = T_W'(width_r);
    end
    priority if (height_r == '0) begin
      eff_h = T_W'(1);
    end else if (32'(height_r) > MAX_DIM) begin
      eff_h = T_W'(MAX_DIM);
    end else begin
      eff_h = T_W'(height_r);
    end
  end

  assign size_eff = {eff_h, eff_w};
  assign busy     = 1'b0;

  twa_scale #(
    .FRAC (COORD_FRAC_BITS),
    .T_W  (T_W),
    .D_W  (D_W)
  ) u_scale (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (start),
    .coord_i ({in_coord_v, in_coord_u}),
    .size_i  (size_eff),
    .ctl_o   (ctl_w[0]),
    .mag_o   (dvd_w[0])
  );

  assign rem_w[0] = '0;

  for (genvar i = 0; i < D_W; i++) begin : g_cell
    twa_cell #(
      .R_W (R_W),
      .D_W (D_W)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl_i  (ctl_w[i]),
      .rem_i  (rem_w[i]),
      .dvd_i  (dvd_w[i]),
      .size_i (size_eff),
      .ctl_o  (ctl_w[i+1]),
      .rem_o  (rem_w[i+1]),
      .dvd_o  (dvd_w[i+1])
    );
  end

  twa_offset #(
    .R_W (R_W)
  ) u_offset (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl_i    (ctl_w[D_W]),
    .rem_i    (rem_w[D_W]),
    .size_i   (size_eff),
    .stride_i (stride_r),
    .bpt_i    (bpt_r),
    .valid_o  (out_valid),
    .col_o    (out_texel_col),
    .row_o    (out_texel_row),
    .offset_o (out_byte_offset),
    .word_o   (out_word_index)
  );

endmodule

@@ sv/twa_scale.sv @@
`timescale 1ns / 1ps
`include "texture_wrap_address_unit_assert.svh"

module twa_scale
  import twa_pkg::*;
#(
  parameter int FRAC = 16,
  parameter int T_W  = 13,
  parameter int D_W  = 22
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           valid_i,
  input  logic [AXES-1:0][COORD_W-1:0]   coord_i,
  input  logic [AXES-1:0][T_W-1:0]       size_i,
  output twa_ctl_t                       ctl_o,
  output logic [AXES-1:0][D_W-1:0]       mag_o
);

  localparam int P_W = D_W + FRAC;
  localparam logic [P_W-1:0] HALF = {{(P_W-1){1'b0}}, 1'b1} << (FRAC - 1);

  logic                      v1_r;
  logic                      v2_r;
  logic [AXES-1:0][P_W-1:0]  prod_r;
  logic [AXES-1:0][P_W-1:0]  prod_nxt;
  logic [AXES-1:0]           neg_r;
  logic [AXES-1:0]           neg_nxt;
  logic [AXES-1:0][D_W-1:0]  mag_r;
  logic [AXES-1:0][D_W-1:0]  mag_nxt;
  logic [AXES-1:0][P_W-1:0]  scaled;
  logic [AXES-1:0][P_W-1:0]  absval;

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      prod_nxt[a] = $signed(coord_i[a]) * $signed({1'b0, size_i[a]});
      scaled[a]   = prod_r[a] - HALF;
      neg_nxt[a]  = scaled[a][P_W-1];
      absval[a]   = neg_nxt[a] ? (~scaled[a] + 1'b1) : scaled[a];
      mag_nxt[a]  = absval[a][P_W-1:FRAC];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= valid_i;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    neg_r  <= neg_nxt;
    mag_r  <= mag_nxt;
  end

  assign ctl_o.valid = v2_r;
  assign ctl_o.neg   = neg_r;
  assign mag_o       = mag_r;

  `TWA_ASSERT_NOW(a_scale_order, v2_r, $past(v1_r), "scale: stage two word without stage one")

endmodule

@@ sv/twa_cell.sv @@
`timescale 1ns / 1ps
`include "texture_wrap_address_unit_assert.svh"

module twa_cell
  import twa_pkg::*;
#(
  parameter int R_W = 12,
  parameter int D_W = 22
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  twa_ctl_t                   ctl_i,
  input  logic [AXES-1:0][R_W-1:0]   rem_i,
  input  logic [AXES-1:0][D_W-1:0]   dvd_i,
  input  logic [AXES-1:0][R_W:0]     size_i,
  output twa_ctl_t                   ctl_o,
  output logic [AXES-1:0][R_W-1:0]   rem_o,
  output logic [AXES-1:0][D_W-1:0]   dvd_o
);

  logic                      valid_r;
  logic [AXES-1:0]           neg_r;
  logic [AXES-1:0][R_W-1:0]  rem_r;
  logic [AXES-1:0][R_W-1:0]  rem_nxt;
  logic [AXES-1:0][D_W-1:0]  dvd_r;
  logic [AXES-1:0][D_W-1:0]  dvd_nxt;
  logic [AXES-1:0][R_W:0]    trial;

  // one restoring step: shift in next dividend bit, subtract size if it fits
  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      trial[a] = {rem_i[a], dvd_i[a][D_W-1]};
      if (trial[a] >= size_i[a]) begin
        trial[a] = trial[a] - size_i[a];
      end
      rem_nxt[a] = trial[a][R_W-1:0];
      dvd_nxt[a] = {dvd_i[a][D_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    neg_r <= ctl_i.neg;
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
  end

  assign ctl_o.valid = valid_r;
  assign ctl_o.neg   = neg_r;
  assign rem_o       = rem_r;
  assign dvd_o       = dvd_r;

  `TWA_ASSERT_NOW(a_cell_from_prev, valid_r, $past(ctl_i.valid), "cell: word without upstream word")
  `TWA_ASSERT_NEXT(a_cell_idle, !ctl_i.valid, !valid_r, "cell: word appeared from idle input")

endmodule

@@ sv/twa_offset.sv @@
`timescale 1ns / 1ps
`include "texture_wrap_address_unit_assert.svh"

module twa_offset
  import twa_pkg::*;
#(
  parameter int R_W = 12
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  twa_ctl_t                   ctl_i,
  input  logic [AXES-1:0][R_W-1:0]   rem_i,
  input  logic [AXES-1:0][R_W:0]     size_i,
  input  logic [STRIDE_W-1:0]        stride_i,
  input  logic [BPT_W-1:0]           bpt_i,
  output logic                       valid_o,
  output logic [TEXEL_W-1:0]         col_o,
  output logic [TEXEL_W-1:0]         row_o,
  output logic [OFFSET_W-1:0]        offset_o,
  output logic [WORD_W-1:0]          word_o
);

  localparam int ROW_P_W = R_W + STRIDE_W;
  localparam int COL_P_W = R_W + BPT_W;
  localparam int SUM_W   = ROW_P_W + 1;

  logic                      vf_r;
  logic                      vm_r;
  logic                      vo_r;
  logic [AXES-1:0][R_W-1:0]  idx_r;
  logic [AXES-1:0][R_W-1:0]  idx_nxt;
  logic [AXES-1:0][R_W:0]    diff;
  logic [AXES-1:0][R_W-1:0]  idx_m_r;
  logic [ROW_P_W-1:0]        row_p_r;
  logic [COL_P_W-1:0]        col_p_r;
  logic [SUM_W-1:0]          sum;
  logic [TEXEL_W-1:0]        col_r;
  logic [TEXEL_W-1:0]        row_r;
  logic [OFFSET_W-1:0]       offset_r;

  // repeat wrap: negative nonzero remainder folds to size - |rem|
  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      diff[a] = size_i[a] - {1'b0, rem_i[a]};
      if (ctl_i.neg[a] && (rem_i[a] != '0)) begin
        idx_nxt[a] = diff[a][R_W-1:0];
      end else begin
        idx_nxt[a] = rem_i[a];
      end
    end
  end

  assign sum = SUM_W'(row_p_r) + SUM_W'(col_p_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= 1'b0;
      vm_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      vf_r <= ctl_i.valid;
      vm_r <= vf_r;
      vo_r <= vm_r;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    idx_m_r  <= idx_r;
    row_p_r  <= idx_r[1] * stride_i;
    col_p_r  <= idx_r[0] * bpt_i;
    col_r    <= TEXEL_W'(idx_m_r[0]);
    row_r    <= TEXEL_W'(idx_m_r[1]);
    offset_r <= OFFSET_W'(sum);
  end

  assign valid_o  = vo_r;
  assign col_o    = col_r;
  assign row_o    = row_r;
  assign offset_o = offset_r;
  assign word_o   = offset_r[OFFSET_W-1:2];

  `TWA_ASSERT_NOW(a_offset_latency, vo_r, $past(ctl_i.valid, 3), "offset: result without word")

endmodule

@@ verif/twa_checker.sv @@
`timescale 1ns / 1ps

module twa_checker
  import twa_pkg::*;
#(
  parameter int MAX_DIM         = 4096,
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  busy,
  input  logic [COORD_W-1:0]    in_coord_u,
  input  logic [COORD_W-1:0]    in_coord_v,
  input  logic                  out_valid,
  input  logic [TEXEL_W-1:0]    out_texel_col,
  input  logic [TEXEL_W-1:0]    out_texel_row,
  input  logic [OFFSET_W-1:0]   out_byte_offset,
  input  logic [WORD_W-1:0]     out_word_index,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fails,
  output int                    pending,
  output int                    checked
);

  typedef struct {
    logic [TEXEL_W-1:0]  col;
    logic [TEXEL_W-1:0]  row;
    logic [OFFSET_W-1:0] offset;
    logic [WORD_W-1:0]   word;
  } texel_addr_t;

  logic [SIZE_REG_W-1:0] width_reg;
  logic [SIZE_REG_W-1:0] height_reg;
  logic [STRIDE_W-1:0]   stride_reg;
  logic [BPT_W-1:0]      bpt_reg;
  texel_addr_t           addr_expect_q[$];
  texel_addr_t           want;
  int                    errs = 0;
  int                    seen = 0;

  // repeat wrap of one axis: scale, minus half texel, trunc toward zero, mod
  function automatic longint wrap_texel_index(logic [COORD_W-1:0] coord,
                                              logic [SIZE_REG_W-1:0] size_raw);
    longint size;
    longint scaled;
    longint whole;
    longint rem;
    if (size_raw == 0) begin
      size = 1;
    end else if (size_raw > MAX_DIM) begin
      size = MAX_DIM;
    end else begin
      size = size_raw;
    end
    scaled = longint'($signed(coord)) * size - (longint'(1) << (COORD_FRAC_BITS - 1));
    if (scaled >= 0) begin
      whole = scaled >>> COORD_FRAC_BITS;
    end else begin
      whole = -((-scaled) >>> COORD_FRAC_BITS);
    end
    rem = whole % size;
    if (rem < 0) begin
      rem = rem + size;
    end
    return rem;
  endfunction

  function automatic texel_addr_t predict_texel_addr(logic [COORD_W-1:0] u,
                                                     logic [COORD_W-1:0] v);
    texel_addr_t a;
    longint      col;
    longint      row;
    longint      off;
    col = wrap_texel_index(u, width_reg);
    row = wrap_texel_index(v, height_reg);
    off = row * longint'(stride_reg) + col * longint'(bpt_reg);
    a.col    = col[TEXEL_W-1:0];
    a.row    = row[TEXEL_W-1:0];
    a.offset = off[OFFSET_W-1:0];
    a.word   = off[OFFSET_W-1:2];
    return a;
  endfunction

  function automatic int field_mismatch(string name, longint exp_val, longint act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      width_reg  = 1;
      height_reg = 1;
      stride_reg = 4;
      bpt_reg    = 4;
      addr_expect_q.delete();
    end else begin
      if (out_valid) begin
        if (addr_expect_q.size() == 0) begin
          $error("unexpected result word: col %0d row %0d offset %0d",
                 out_texel_col, out_texel_row, out_byte_offset);
          errs++;
        end else begin
          want = addr_expect_q.pop_front();
          errs += field_mismatch("texel_col", want.col, out_texel_col);
          errs += field_mismatch("texel_row", want.row, out_texel_row);
          errs += field_mismatch("byte_offset", want.offset, out_byte_offset);
          errs += field_mismatch("word_index", want.word, out_word_index);
          seen++;
        end
      end
      if (start && !busy) begin
        addr_expect_q.push_back(predict_texel_addr(in_coord_u, in_coord_v));
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_TEX_WIDTH:       width_reg  = cfg_wdata[SIZE_REG_W-1:0];
          REG_TEX_HEIGHT:      height_reg = cfg_wdata[SIZE_REG_W-1:0];
          REG_ROW_STRIDE:      stride_reg = cfg_wdata[STRIDE_W-1:0];
          REG_BYTES_PER_TEXEL: bpt_reg    = cfg_wdata[BPT_W-1:0];
          default: ;
        endcase
      end
    end
    fails   <= errs;
    pending <= addr_expect_q.size();
    checked <= seen;
  end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import twa_pkg::*;

  localparam int LATENCY         = 27;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int RAND_PHASES     = 12;
  localparam int WORDS_PER_PHASE = 120;
  localparam logic [COORD_W-1:0] CORNERS [7] = '{
    24'h7FFFFF, 24'h800000, 24'h000000, 24'hFFFFFF, 24'h000001, 24'h008000, 24'hFF8000
  };

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [COORD_W-1:0]    in_coord_u;
  logic [COORD_W-1:0]    in_coord_v;
  logic                  out_valid;
  logic [TEXEL_W-1:0]    out_texel_col;
  logic [TEXEL_W-1:0]    out_texel_row;
  logic [OFFSET_W-1:0]   out_byte_offset;
  logic [WORD_W-1:0]     out_word_index;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int                    fails;
  int                    pending;
  int                    checked;
  int                    cycle_count = 0;
  int                    settings_seen = 0;
  bit                    idle_on;
  logic [SIZE_REG_W-1:0] width_set;
  logic [SIZE_REG_W-1:0] height_set;

  texture_wrap_address_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_coord_u      (in_coord_u),
    .in_coord_v      (in_coord_v),
    .out_valid       (out_valid),
    .out_texel_col   (out_texel_col),
    .out_texel_row   (out_texel_row),
    .out_byte_offset (out_byte_offset),
    .out_word_index  (out_word_index),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  twa_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_coord_u      (in_coord_u),
    .in_coord_v      (in_coord_v),
    .out_valid       (out_valid),
    .out_texel_col   (out_texel_col),
    .out_texel_row   (out_texel_row),
    .out_byte_offset (out_byte_offset),
    .out_word_index  (out_word_index),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .fails           (fails),
    .pending         (pending),
    .checked         (checked)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("tb: timeout after %0d cycles, %0d words pending", cycle_count, pending);
    $display("tb: failure");
    $finish;
  end

  function automatic int eff_dim(logic [SIZE_REG_W-1:0] raw);
    if (raw == 0) begin
      return 1;
    end
    return (raw > 4096) ? 4096 : int'(raw);
  endfunction

  // mix of full-range, near-origin, texel-boundary and corner coordinates
  function automatic logic [COORD_W-1:0] pick_coord(int dim);
    int mode;
    int k;
    int base;
    int turns;
    mode = $urandom_range(0, 9);
    case (mode)
      0, 1, 2: return COORD_W'($urandom());
      3, 4:    return COORD_W'($urandom_range(0, 32'h40000)) - 24'h20000;
      5, 6, 7: begin
        k     = $urandom_range(0, 2 * dim + 2) - dim - 1;
        base  = (k * 65536 + 32768) / dim;
        turns = int'($urandom_range(0, 200)) - 100;
        return COORD_W'(base + int'($urandom_range(0, 2)) - 1 + turns * 65536);
      end
      8:       return CORNERS[$urandom_range(0, 6)];
      default: return {1'b1, 23'($urandom())};
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_dim_raw();
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1:       return 16'd4096;
      2:       return 16'($urandom());
      3:       return 16'd1;
      4, 5:    return 16'(1 << $urandom_range(0, 12));
      default: return 16'($urandom_range(1, 4096));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_stride_raw();
    case ($urandom_range(0, 7))
      0, 1, 2, 3: return 16'($urandom());
      4:          return 16'd0;
      5:          return 16'hFFFF;
      default:    return 16'($urandom_range(1, 2048));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_bpt_raw();
    if ($urandom_range(0, 1) == 0) begin
      return 16'($urandom());
    end
    return 16'(1 << $urandom_range(0, 3));
  endfunction

  task automatic send_word(logic [COORD_W-1:0] u, logic [COORD_W-1:0] v);
    @(negedge clk);
    start      <= 1'b1;
    in_coord_u <= u;
    in_coord_v <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (idle_on && $urandom_range(0, 99) < 33) begin
      @(negedge clk);
      start <= 1'b0;
      repeat ($urandom_range(0, 1)) @(negedge clk);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic cfg_write(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
  endtask

  task automatic apply_setting(logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h,
                               logic [CFG_DATA_W-1:0] stride, logic [CFG_DATA_W-1:0] bpt);
    drain();
    cfg_write(REG_TEX_WIDTH, w);
    cfg_write(REG_TEX_HEIGHT, h);
    cfg_write(REG_ROW_STRIDE, stride);
    cfg_write(REG_BYTES_PER_TEXEL, bpt);
    @(negedge clk);
    cfg_we     <= 1'b0;
    width_set  = w[SIZE_REG_W-1:0];
    height_set = h[SIZE_REG_W-1:0];
    settings_seen++;
  endtask

  initial begin
    rst_n      = 1'b0;
    start      = 1'b0;
    in_coord_u = '0;
    in_coord_v = '0;
    cfg_we     = 1'b0;
    cfg_index  = REG_TEX_WIDTH;
    cfg_wdata  = '0;
    idle_on    = 1'b1;
    width_set  = 1;
    height_set = 1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset values: 1x1 texture, stride 4, 4 bytes per texel
    send_word(24'h000000, 24'h000000);
    send_word(24'h7FFFFF, 24'h800000);
    send_word(24'h800000, 24'h7FFFFF);
    send_word(24'hFFFFFF, 24'h000001);
    send_word(24'h008000, 24'hFF8000);

    // largest sizes, offset wraps at 27 bits
    apply_setting(16'd4096, 16'd4096, 16'hFFFF, 16'hFFFF);
    send_word(24'h7FFFFF, 24'h7FFFFF);
    send_word(24'h00FFFF, 24'h00FFFF);
    send_word(24'h800000, 24'h800000);
    send_word(24'h010000, 24'h010000);
    send_word(24'hFF0000, 24'h00FFF8);
    send_word(24'h000008, 24'h000007);
    send_word(24'hFFFFF8, 24'hFFFFF9);

    // zero sizes act as one, zero stride and texel size
    apply_setting(16'd0, 16'd0, 16'd0, 16'd0);
    send_word(24'h7FFFFF, 24'h800000);
    send_word(24'h123456, 24'hABCDEF);
    send_word(24'hFFFFFF, 24'hFFFFFF);

    // oversized sizes clamp to 4096
    apply_setting(16'hFFFF, 16'd5000, 16'd1, 16'd1);
    send_word(24'h7FFFFF, 24'h800000);
    send_word(24'h010000, 24'hFF0000);
    send_word(24'h012345, 24'h054321);

    // odd sizes, negative wrap
    apply_setting(16'd3, 16'd7, 16'h8000, 16'd8);
    send_word(24'hFF0000, 24'hFFFFFF);
    send_word(24'h005555, 24'hAAAAAA);
    send_word(24'h800000, 24'h7FFFFF);
    send_word(24'h002AAB, 24'h002492);

    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      idle_on = !(phase == 4 || phase == 5);
      apply_setting(pick_dim_raw(), pick_dim_raw(), pick_stride_raw(), pick_bpt_raw());
      repeat (WORDS_PER_PHASE) begin
        send_word(pick_coord(eff_dim(width_set)), pick_coord(eff_dim(height_set)));
        if ($urandom_range(0, 149) == 0) begin
          drain();
        end
      end
    end

    drain();
    repeat (2 * LATENCY) @(negedge clk);
    $display("tb: %0d address words checked over %0d texture settings", checked,
             settings_seen);
    $display("tb: sizes of zero, one, 4096 and above, negative wrap and offset overflow");
    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
